FILE: rtl/segment_rectangle_hit_test_defines.svh
// Assertion macros shared by the segment/rectangle hit test RTL.
// Expanded inside modules that have clk and rst_n in scope.
`ifndef SEGMENT_RECTANGLE_HIT_TEST_DEFINES_SVH
`define SEGMENT_RECTANGLE_HIT_TEST_DEFINES_SVH

// Plain concurrent check, off while reset is held.
`define SRHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Overlapping implication check, off while reset is held.
`define SRHT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/srht_pkg.sv
// Package for the segment/rectangle hit test: widths and stage payload types.
// No dependencies.
`timescale 1ns / 1ps

package srht_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int NUM_EDGES  = 4;

  // Coordinate differences, one register stage.
  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;   // end_x - start_x
    logic signed [DIFF_W-1:0] dy;   // end_y - start_y
    logic signed [DIFF_W-1:0] w;    // right - left
    logic signed [DIFF_W-1:0] h;    // bottom - top
    logic signed [DIFF_W-1:0] syt;  // start_y - top
    logic signed [DIFF_W-1:0] syb;  // start_y - bottom
    logic signed [DIFF_W-1:0] sxl;  // start_x - left
    logic signed [DIFF_W-1:0] sxr;  // start_x - right
  } diff_t;

  // The ten distinct products the four axis-aligned edge tests need.
  typedef struct packed {
    logic signed [PROD_W-1:0] w_dy;
    logic signed [PROD_W-1:0] h_dx;
    logic signed [PROD_W-1:0] w_syt;
    logic signed [PROD_W-1:0] w_syb;
    logic signed [PROD_W-1:0] h_sxl;
    logic signed [PROD_W-1:0] h_sxr;
    logic signed [PROD_W-1:0] dx_syt;
    logic signed [PROD_W-1:0] dx_syb;
    logic signed [PROD_W-1:0] dy_sxl;
    logic signed [PROD_W-1:0] dy_sxr;
  } prod_t;

  // Stage advance control shared by all pipeline stages.
  typedef struct packed {
    logic en;     // advance the whole pipe this cycle
    logic valid;  // item present at the stage input
  } stage_ctl_t;

endpackage

FILE: rtl/srht_diff.sv
// Stage 1 of the hit test: coordinate differences.
// Depends on srht_pkg.
`timescale 1ns / 1ps

module srht_diff (
  input  logic                                clk,
  input  logic                                rst_n,
  input  srht_pkg::stage_ctl_t                ctl,
  input  logic signed [srht_pkg::COORD_BITS-1:0] start_x,
  input  logic signed [srht_pkg::COORD_BITS-1:0] start_y,
  input  logic signed [srht_pkg::COORD_BITS-1:0] end_x,
  input  logic signed [srht_pkg::COORD_BITS-1:0] end_y,
  input  logic signed [srht_pkg::COORD_BITS-1:0] rect_left,
  input  logic signed [srht_pkg::COORD_BITS-1:0] rect_top,
  input  logic signed [srht_pkg::COORD_BITS-1:0] rect_right,
  input  logic signed [srht_pkg::COORD_BITS-1:0] rect_bottom,
  output logic                                valid,
  output srht_pkg::diff_t                     diff
);
  import srht_pkg::*;

  localparam int MSB = COORD_BITS - 1;

  logic  valid_r;
  diff_t diff_r, diff_nxt;

  // Sign-extend by one bit so every difference is exact.
  always_comb begin
    diff_nxt.dx  = {end_x[MSB], end_x}           - {start_x[MSB], start_x};
    diff_nxt.dy  = {end_y[MSB], end_y}           - {start_y[MSB], start_y};
    diff_nxt.w   = {rect_right[MSB], rect_right} - {rect_left[MSB], rect_left};
    diff_nxt.h   = {rect_bottom[MSB], rect_bottom} - {rect_top[MSB], rect_top};
    diff_nxt.syt = {start_y[MSB], start_y}       - {rect_top[MSB], rect_top};
    diff_nxt.syb = {start_y[MSB], start_y}       - {rect_bottom[MSB], rect_bottom};
    diff_nxt.sxl = {start_x[MSB], start_x}       - {rect_left[MSB], rect_left};
    diff_nxt.sxr = {start_x[MSB], start_x}       - {rect_right[MSB], rect_right};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.en) begin
      valid_r <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      diff_r <= diff_nxt;
    end
  end

  assign valid = valid_r;
  assign diff  = diff_r;

endmodule

FILE: rtl/srht_mult.sv
// Stage 2 of the hit test: ten parallel signed multiplies, registered.
// Depends on srht_pkg.
`timescale 1ns / 1ps

module srht_mult (
  input  logic                 clk,
  input  logic                 rst_n,
  input  srht_pkg::stage_ctl_t ctl,
  input  srht_pkg::diff_t      diff,
  output logic                 valid,
  output srht_pkg::prod_t      prod
);
  import srht_pkg::*;

  logic  valid_r;
  prod_t prod_r, prod_nxt;

  always_comb begin
    prod_nxt.w_dy   = PROD_W'(diff.w)  * PROD_W'(diff.dy);
    prod_nxt.h_dx   = PROD_W'(diff.h)  * PROD_W'(diff.dx);
    prod_nxt.w_syt  = PROD_W'(diff.w)  * PROD_W'(diff.syt);
    prod_nxt.w_syb  = PROD_W'(diff.w)  * PROD_W'(diff.syb);
    prod_nxt.h_sxl  = PROD_W'(diff.h)  * PROD_W'(diff.sxl);
    prod_nxt.h_sxr  = PROD_W'(diff.h)  * PROD_W'(diff.sxr);
    prod_nxt.dx_syt = PROD_W'(diff.dx) * PROD_W'(diff.syt);
    prod_nxt.dx_syb = PROD_W'(diff.dx) * PROD_W'(diff.syb);
    prod_nxt.dy_sxl = PROD_W'(diff.dy) * PROD_W'(diff.sxl);
    prod_nxt.dy_sxr = PROD_W'(diff.dy) * PROD_W'(diff.sxr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.en) begin
      valid_r <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      prod_r <= prod_nxt;
    end
  end

  assign valid = valid_r;
  assign prod  = prod_r;

endmodule

FILE: rtl/srht_edge.sv
// Stages 3 and 4 of the hit test: per-edge den/na/nb, then range tests and OR.
// Depends on srht_pkg.
`timescale 1ns / 1ps

module srht_edge (
  input  logic                 clk,
  input  logic                 rst_n,
  input  srht_pkg::stage_ctl_t ctl,
  input  srht_pkg::prod_t      prod,
  output logic                 valid,
  output logic                 hit
);
  import srht_pkg::*;

  localparam logic [1:0] EDGE_TOP    = 2'd0;
  localparam logic [1:0] EDGE_RIGHT  = 2'd1;
  localparam logic [1:0] EDGE_BOTTOM = 2'd2;
  localparam logic [1:0] EDGE_LEFT   = 2'd3;

  typedef struct packed {
    logic signed [SUM_W-1:0] den;
    logic signed [SUM_W-1:0] na;
    logic signed [SUM_W-1:0] nb;
  } edge_num_t;

  // n/d within [0, 1], with d known nonzero
  function automatic logic in_unit(input logic signed [SUM_W-1:0] n,
                                   input logic signed [SUM_W-1:0] d);
    logic ok;
    if (d[SUM_W-1]) begin
      ok = (n[SUM_W-1] || (n == '0)) && (n >= d);
    end else begin
      ok = !n[SUM_W-1] && (n <= d);
    end
    return ok;
  endfunction

  logic                        s3_valid_r;
  edge_num_t [NUM_EDGES-1:0]   num_r, num_nxt;
  logic      [NUM_EDGES-1:0]   edge_hit;
  logic                        valid_r;
  logic                        hit_r, hit_nxt;

  // Edges run top, right, bottom, left; each has one zero delta component.
  always_comb begin
    num_nxt[EDGE_TOP].den    = -SUM_W'(prod.w_dy);
    num_nxt[EDGE_TOP].na     =  SUM_W'(prod.w_syt);
    num_nxt[EDGE_TOP].nb     =  SUM_W'(prod.dx_syt) - SUM_W'(prod.dy_sxl);
    num_nxt[EDGE_RIGHT].den  =  SUM_W'(prod.h_dx);
    num_nxt[EDGE_RIGHT].na   = -SUM_W'(prod.h_sxr);
    num_nxt[EDGE_RIGHT].nb   =  SUM_W'(prod.dx_syt) - SUM_W'(prod.dy_sxr);
    num_nxt[EDGE_BOTTOM].den =  SUM_W'(prod.w_dy);
    num_nxt[EDGE_BOTTOM].na  = -SUM_W'(prod.w_syb);
    num_nxt[EDGE_BOTTOM].nb  =  SUM_W'(prod.dx_syb) - SUM_W'(prod.dy_sxr);
    num_nxt[EDGE_LEFT].den   = -SUM_W'(prod.h_dx);
    num_nxt[EDGE_LEFT].na    =  SUM_W'(prod.h_sxl);
    num_nxt[EDGE_LEFT].nb    =  SUM_W'(prod.dx_syb) - SUM_W'(prod.dy_sxl);
  end

  // Drop parallel edges and the case where both numerators are zero.
  always_comb begin
    for (int i = 0; i < NUM_EDGES; i++) begin
      edge_hit[i] = (num_r[i].den != '0)
                    && in_unit(num_r[i].na, num_r[i].den)
                    && in_unit(num_r[i].nb, num_r[i].den)
                    && !((num_r[i].na == '0) && (num_r[i].nb == '0));
    end
    hit_nxt = |edge_hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
      valid_r    <= 1'b0;
    end else if (ctl.en) begin
      s3_valid_r <= ctl.valid;
      valid_r    <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      num_r <= num_nxt;
      hit_r <= hit_nxt;
    end
  end

  assign valid = valid_r;
  assign hit   = hit_r;

endmodule

FILE: rtl/segment_rectangle_hit_test.sv
// Top level of the segment/rectangle hit test: four-stage pipeline.
// Depends on srht_pkg, srht_diff, srht_mult, srht_edge and the defines header.
`timescale 1ns / 1ps
`include "segment_rectangle_hit_test_defines.svh"

// Channel   Direction  Ports                                  Transfer when
// -------   ---------  -------------------------------------  -------------------
// in        sink       in_valid, in_stall, in_<8 coordinates>  in_valid & !in_stall
// out       source     out_valid, out_stall, out_hit           out_valid & !out_stall
//
// One item enters per cycle while in_stall is low; each result passes the stage registers
// in order (differences, multiplies, per-edge sums, range tests). Throughput is set by
// the fully pipelined multiplier stage: one item per clock unless the output stalls.
// Synchronous active-low reset clears every stage valid bit; payload is not reset.
// A stalled result freezes the whole pipe in place, so in_stall follows
// out_valid & out_stall and nothing is lost or repeated.

module segment_rectangle_hit_test (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [srht_pkg::COORD_BITS-1:0] in_start_x,
  input  logic signed [srht_pkg::COORD_BITS-1:0] in_start_y,
  input  logic signed [srht_pkg::COORD_BITS-1:0] in_end_x,
  input  logic signed [srht_pkg::COORD_BITS-1:0] in_end_y,
  input  logic signed [srht_pkg::COORD_BITS-1:0] in_rect_left,
  input  logic signed [srht_pkg::COORD_BITS-1:0] in_rect_top,
  input  logic signed [srht_pkg::COORD_BITS-1:0] in_rect_right,
  input  logic signed [srht_pkg::COORD_BITS-1:0] in_rect_bottom,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_hit
);
  import srht_pkg::*;

  logic       adv;       // advance every stage this cycle
  logic       s1_valid;
  logic       s2_valid;
  diff_t      s1_diff;
  prod_t      s2_prod;
  stage_ctl_t ctl_s1, ctl_s2, ctl_s3;

  // Hold everything while a finished result waits; otherwise advance,
  // bubbles included.
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  assign ctl_s1 = '{en: adv, valid: in_valid};
  assign ctl_s2 = '{en: adv, valid: s1_valid};
  assign ctl_s3 = '{en: adv, valid: s2_valid};

  // Stage 1: exact coordinate differences.
  srht_diff u_diff (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl_s1),
    .start_x     (in_start_x),
    .start_y     (in_start_y),
    .end_x       (in_end_x),
    .end_y       (in_end_y),
    .rect_left   (in_rect_left),
    .rect_top    (in_rect_top),
    .rect_right  (in_rect_right),
    .rect_bottom (in_rect_bottom),
    .valid       (s1_valid),
    .diff        (s1_diff)
  );

  // Stage 2: the ten cross-product terms.
  srht_mult u_mult (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl_s2),
    .diff  (s1_diff),
    .valid (s2_valid),
    .prod  (s2_prod)
  );

  // Stages 3 and 4: per-edge den/na/nb, then range tests and the OR of edges.
  srht_edge u_edge (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl_s3),
    .prod  (s2_prod),
    .valid (out_valid),
    .hit   (out_hit)
  );

  // A transfer followed by advance through every later stage must show a result.
  `SRHT_ASSERT(a_latency, (in_valid && !in_stall) ##1 !in_stall ##1 !in_stall ##1 !in_stall |=> out_valid, "result missing four stages after transfer")
  // A result drops only after its transfer or by reset.
  `SRHT_ASSERT_IMP(a_no_drop, $fell(out_valid), (!$past(out_stall) || !$past(rst_n)), "result dropped without a transfer")
  // With no result waiting, the input side is never stalled.
  `SRHT_ASSERT_IMP(a_no_idle_stall, !out_valid, !in_stall, "input stalled with empty output")

endmodule
